FILE: rtl/cpit_pkg.sv
`default_nettype none
package cpit_pkg;

  localparam int CW    = 16;          // coordinate width
  localparam int DW    = CW + 1;      // coordinate difference
  localparam int SQW   = 2 * CW + 1;  // sum of two squares
  localparam int DETW  = 2 * CW + 3;  // determinant
  localparam int NUMW  = SQW + DW + 2; // centre numerators
  localparam int DENW  = DETW + 1;    // twice the determinant
  localparam int QB    = 34;          // quotient bits, top bit flags overflow
  localparam int CMPW  = DENW + QB;   // trial divisor width
  localparam int OW    = 32;          // output width
  localparam int DXW   = OW + 1;      // centre to point difference
  localparam int D2W   = 2 * DXW;     // one squared difference
  localparam int RW    = D2W + 1;     // squared distance
  localparam int RTW   = 32;          // root bits
  localparam int SRW   = RTW + 3;     // root remainder
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;

  localparam logic signed [OW-1:0] CENTRE_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] CENTRE_MIN = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic signed [CW-1:0] probe_x;
    logic signed [CW-1:0] probe_y;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] center_x;
    logic signed [OW-1:0] center_y;
    logic [OW-1:0]        circle_radius;
    logic                 inside_res;
    logic                 degenerate;
  } out_t;

  typedef struct packed {
    logic signed [NUMW-1:0] nx;
    logic signed [NUMW-1:0] ny;
    logic signed [DETW-1:0] det;
    logic signed [CW-1:0]   ax;
    logic signed [CW-1:0]   ay;
    logic signed [CW-1:0]   px;
    logic signed [CW-1:0]   py;
  } fq_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage
`default_nettype wire

FILE: rtl/circumcircle_point_in_test_unit.sv
`default_nettype none
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_data (in_t)
// out     | output    | out_valid/out_stall | out_data (out_t)
//
// One request per cycle sustained while the queue has room and the output is
// not stalled; each request passes through the two front stages, the queue,
// the 34 stage divider and the 32 stage square root in the back end.
// Reset is synchronous and clears all valid flags and queue pointers.
// The front end stalls only when its four entry queue is full; the back end
// holds as a whole while a finished result is stalled at the output.
module circumcircle_point_in_test_unit import cpit_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  wire  out_stall,
  output out_t out_data
);

  logic     push, pop;
  fq_t      push_data, head;
  fifo_st_t fst;

  cpit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .fst       (fst)
  );

  cpit_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .fst       (fst)
  );

  cpit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .fst       (fst),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !fst.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fst.empty) else $error("queue read while empty");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.center_x == '0 &&
      out_data.center_y == '0 && out_data.circle_radius == '0 &&
      !out_data.inside_res)) else $error("degenerate result not cleared");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

FILE: rtl/cpit_front.sv
`default_nettype none
module cpit_front import cpit_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  output logic      push,
  output fq_t       push_data,
  input  fifo_st_t  fst
);

  logic en;
  logic v1_r, v2_r;
  in_t  c1_r;
  logic signed [DW-1:0]  dbc_r, dca_r, dab_r, ecb_r, eac_r, eba_r;
  logic signed [SQW-1:0] a2_r, b2_r, c2_r;
  fq_t  f2_r;

  assign en       = !(v2_r && fst.full);
  assign in_stall = !en;
  assign push     = v2_r && !fst.full;
  assign push_data = f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r  <= in_data;
      dbc_r <= DW'(in_data.vertex_b_y) - DW'(in_data.vertex_c_y);
      dca_r <= DW'(in_data.vertex_c_y) - DW'(in_data.vertex_a_y);
      dab_r <= DW'(in_data.vertex_a_y) - DW'(in_data.vertex_b_y);
      ecb_r <= DW'(in_data.vertex_c_x) - DW'(in_data.vertex_b_x);
      eac_r <= DW'(in_data.vertex_a_x) - DW'(in_data.vertex_c_x);
      eba_r <= DW'(in_data.vertex_b_x) - DW'(in_data.vertex_a_x);
      a2_r  <= SQW'(in_data.vertex_a_x) * SQW'(in_data.vertex_a_x)
             + SQW'(in_data.vertex_a_y) * SQW'(in_data.vertex_a_y);
      b2_r  <= SQW'(in_data.vertex_b_x) * SQW'(in_data.vertex_b_x)
             + SQW'(in_data.vertex_b_y) * SQW'(in_data.vertex_b_y);
      c2_r  <= SQW'(in_data.vertex_c_x) * SQW'(in_data.vertex_c_x)
             + SQW'(in_data.vertex_c_y) * SQW'(in_data.vertex_c_y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r.det <= DETW'(c1_r.vertex_a_x) * DETW'(dbc_r)
                + DETW'(c1_r.vertex_b_x) * DETW'(dca_r)
                + DETW'(c1_r.vertex_c_x) * DETW'(dab_r);
      f2_r.nx  <= NUMW'(a2_r) * NUMW'(dbc_r) + NUMW'(b2_r) * NUMW'(dca_r)
                + NUMW'(c2_r) * NUMW'(dab_r);
      f2_r.ny  <= NUMW'(a2_r) * NUMW'(ecb_r) + NUMW'(b2_r) * NUMW'(eac_r)
                + NUMW'(c2_r) * NUMW'(eba_r);
      f2_r.ax  <= c1_r.vertex_a_x;
      f2_r.ay  <= c1_r.vertex_a_y;
      f2_r.px  <= c1_r.probe_x;
      f2_r.py  <= c1_r.probe_y;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cpit_fifo.sv
`default_nettype none
module cpit_fifo import cpit_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       push,
  input  fq_t       push_data,
  input  wire       pop,
  output fq_t       head,
  output fifo_st_t  fst
);

  fq_t              mem_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wp_r, rp_r;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;

  assign head      = mem_r[rp_r];
  assign fst.full  = (cnt_r == (FQ_AW+1)'(FQ_DEPTH));
  assign fst.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: rtl/cpit_back.sv
`default_nettype none
module cpit_back import cpit_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  fq_t       head,
  input  fifo_st_t  fst,
  output logic      pop,
  output logic      out_valid,
  input  wire       out_stall,
  output out_t      out_data
);

  typedef struct packed {
    logic                 v;
    logic [NUMW-1:0]      rx;
    logic [NUMW-1:0]      ry;
    logic [QB-1:0]        qx;
    logic [QB-1:0]        qy;
    logic [DENW-1:0]      d;
    logic                 negx;
    logic                 negy;
    logic                 degen;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } dst_t;

  typedef struct packed {
    logic                 v;
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
    logic                 degen;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
  } sst_t;

  typedef struct packed {
    logic                 v;
    logic [D2W-1:0]       dx2;
    logic [D2W-1:0]       dy2;
    logic [D2W-1:0]       px2;
    logic [D2W-1:0]       py2;
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
    logic                 degen;
  } dd_t;

  typedef struct packed {
    logic                 v;
    logic [RW-1:0]        ra;
    logic [RW-1:0]        rp;
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
    logic                 degen;
  } sm_t;

  typedef struct packed {
    logic                 v;
    logic [2*RTW-1:0]     s;
    logic [SRW-1:0]       rem;
    logic [RTW-1:0]       root;
    logic                 sat;
    logic                 probe_in;
    logic signed [OW-1:0] ox;
    logic signed [OW-1:0] oy;
    logic                 degen;
  } qst_t;

  logic be;
  dst_t ds_r [QB+1];
  sst_t ss_r;
  dd_t  dd_r;
  sm_t  sm_r;
  qst_t qs_r [RTW+1];
  out_t out_r;
  logic out_valid_r;

  // advance the whole back end unless a finished result is held
  assign be        = !(out_valid_r && out_stall);
  assign pop       = be && !fst.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // entry stage: magnitudes and quotient signs
  dst_t ds0_nxt;
  logic signed [DENW-1:0] den;
  always_comb begin
    den = {head.det, 1'b0};
    ds0_nxt.v     = !fst.empty;
    ds0_nxt.rx    = head.nx[NUMW-1] ? NUMW'(-head.nx) : NUMW'(head.nx);
    ds0_nxt.ry    = head.ny[NUMW-1] ? NUMW'(-head.ny) : NUMW'(head.ny);
    ds0_nxt.qx    = '0;
    ds0_nxt.qy    = '0;
    ds0_nxt.d     = den[DENW-1] ? DENW'(-den) : DENW'(den);
    ds0_nxt.negx  = head.nx[NUMW-1] ^ den[DENW-1];
    ds0_nxt.negy  = head.ny[NUMW-1] ^ den[DENW-1];
    ds0_nxt.degen = (head.det == '0);
    ds0_nxt.ax    = head.ax;
    ds0_nxt.ay    = head.ay;
    ds0_nxt.px    = head.px;
    ds0_nxt.py    = head.py;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ds_r[0].v <= 1'b0;
    else if (be) ds_r[0] <= ds0_nxt;
  end

  // restoring division, one quotient bit per stage, both axes side by side
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int Sh = QB - 1 - k;
    dst_t ds_nxt;
    logic [CMPW-1:0] dsh;
    always_comb begin
      ds_nxt = ds_r[k];
      dsh    = CMPW'(ds_r[k].d) << Sh;
      if (CMPW'(ds_r[k].rx) >= dsh) begin
        ds_nxt.rx     = NUMW'(CMPW'(ds_r[k].rx) - dsh);
        ds_nxt.qx[Sh] = 1'b1;
      end
      if (CMPW'(ds_r[k].ry) >= dsh) begin
        ds_nxt.ry     = NUMW'(CMPW'(ds_r[k].ry) - dsh);
        ds_nxt.qy[Sh] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) ds_r[k+1].v <= 1'b0;
      else if (be) ds_r[k+1] <= ds_nxt;
    end
  end

  function automatic logic signed [OW-1:0] sat_q(input logic [QB-1:0] q, input logic neg);
    logic signed [OW-1:0] r;
    if (neg) begin
      if (q[QB-1] || q[QB-2:0] > (QB-1)'({1'b1, {(OW-1){1'b0}}})) r = CENTRE_MIN;
      else r = OW'(-q[OW-1:0]);
    end else begin
      if (q[QB-1] || q[QB-2:0] > (QB-1)'(CENTRE_MAX)) r = CENTRE_MAX;
      else r = q[OW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) ss_r.v <= 1'b0;
    else if (be) begin
      ss_r.v     <= ds_r[QB].v;
      ss_r.ox    <= sat_q(ds_r[QB].qx, ds_r[QB].negx);
      ss_r.oy    <= sat_q(ds_r[QB].qy, ds_r[QB].negy);
      ss_r.degen <= ds_r[QB].degen;
      ss_r.ax    <= ds_r[QB].ax;
      ss_r.ay    <= ds_r[QB].ay;
      ss_r.px    <= ds_r[QB].px;
      ss_r.py    <= ds_r[QB].py;
    end
  end

  logic signed [DXW-1:0] dax, day, dpx, dpy;
  logic [DXW-1:0] max, may, mpx, mpy;
  always_comb begin
    dax = DXW'(ss_r.ox) - DXW'(ss_r.ax);
    day = DXW'(ss_r.oy) - DXW'(ss_r.ay);
    dpx = DXW'(ss_r.ox) - DXW'(ss_r.px);
    dpy = DXW'(ss_r.oy) - DXW'(ss_r.py);
    max = dax[DXW-1] ? DXW'(-dax) : DXW'(dax);
    may = day[DXW-1] ? DXW'(-day) : DXW'(day);
    mpx = dpx[DXW-1] ? DXW'(-dpx) : DXW'(dpx);
    mpy = dpy[DXW-1] ? DXW'(-dpy) : DXW'(dpy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dd_r.v <= 1'b0;
    else if (be) begin
      dd_r.v     <= ss_r.v;
      dd_r.dx2   <= D2W'(max) * D2W'(max);
      dd_r.dy2   <= D2W'(may) * D2W'(may);
      dd_r.px2   <= D2W'(mpx) * D2W'(mpx);
      dd_r.py2   <= D2W'(mpy) * D2W'(mpy);
      dd_r.ox    <= ss_r.ox;
      dd_r.oy    <= ss_r.oy;
      dd_r.degen <= ss_r.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sm_r.v <= 1'b0;
    else if (be) begin
      sm_r.v     <= dd_r.v;
      sm_r.ra    <= RW'(dd_r.dx2) + RW'(dd_r.dy2);
      sm_r.rp    <= RW'(dd_r.px2) + RW'(dd_r.py2);
      sm_r.ox    <= dd_r.ox;
      sm_r.oy    <= dd_r.oy;
      sm_r.degen <= dd_r.degen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) qs_r[0].v <= 1'b0;
    else if (be) begin
      qs_r[0].v        <= sm_r.v;
      qs_r[0].s        <= sm_r.ra[2*RTW-1:0];
      qs_r[0].rem      <= '0;
      qs_r[0].root     <= '0;
      qs_r[0].sat      <= (sm_r.ra[RW-1:2*RTW] != '0);
      qs_r[0].probe_in <= (sm_r.rp < sm_r.ra);
      qs_r[0].ox       <= sm_r.ox;
      qs_r[0].oy       <= sm_r.oy;
      qs_r[0].degen    <= sm_r.degen;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < RTW; k++) begin : g_sqrt
    qst_t qs_nxt;
    logic [SRW-1:0] rem2, trial;
    always_comb begin
      qs_nxt = qs_r[k];
      rem2   = {qs_r[k].rem[SRW-3:0], qs_r[k].s[2*RTW-1 -: 2]};
      trial  = SRW'({qs_r[k].root, 2'b01});
      qs_nxt.s = {qs_r[k].s[2*RTW-3:0], 2'b00};
      if (rem2 >= trial) begin
        qs_nxt.rem  = rem2 - trial;
        qs_nxt.root = {qs_r[k].root[RTW-2:0], 1'b1};
      end else begin
        qs_nxt.rem  = rem2;
        qs_nxt.root = {qs_r[k].root[RTW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) qs_r[k+1].v <= 1'b0;
      else if (be) qs_r[k+1] <= qs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (be) out_valid_r <= qs_r[RTW].v;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      if (qs_r[RTW].degen) begin
        out_r <= '{center_x: '0, center_y: '0, circle_radius: '0,
                   inside_res: 1'b0, degenerate: 1'b1};
      end else begin
        out_r.center_x      <= qs_r[RTW].ox;
        out_r.center_y      <= qs_r[RTW].oy;
        out_r.circle_radius <= qs_r[RTW].sat ? {OW{1'b1}} : qs_r[RTW].root;
        out_r.inside_res    <= qs_r[RTW].probe_in;
        out_r.degenerate    <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
